// ===== hw/rtl/gelc_pkg.sv =====
// ----------------------------------------------------------------------------
// gelc_pkg: shared types and constants for the loss chain
// splitmix64 constants, register indexes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package gelc_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;

  localparam logic [WordW-1:0] MixAdd  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] MixMul1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] MixMul2 = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned Shift1 = 30;
  localparam int unsigned Shift2 = 27;
  localparam int unsigned Shift3 = 31;

  typedef enum logic [1:0] {
    REG_RAW_SEED  = 2'd0,
    REG_ENTER_BAD = 2'd1,
    REG_LEAVE_BAD = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ADD  = 5'b00010,
    S_MUL  = 5'b00100,
    S_XOR  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    PP_LO_LO = 2'd0,
    PP_LO_HI = 2'd1,
    PP_HI_LO = 2'd2,
    PP_NONE  = 2'd3
  } pp_sel_t;

endpackage : gelc_pkg

`default_nettype wire

// ===== hw/rtl/gilbert_elliott_loss_chain.sv =====
// ----------------------------------------------------------------------------
// gilbert_elliott_loss_chain: two-state packet loss generator
// drop decision from the chain state, next state from a splitmix64 draw
// ----------------------------------------------------------------------------
//  channel   signals                       width   direction
//  input     in_valid/in_ready, restart     1       in
//  output    out_valid/out_ready, drop,     1, 1    out
//            chain_bad_next
//  config    cfg_we, cfg_index, cfg_data    1, 2, 64 in
//
//  one splitmix64 runs as an add, two rounds of three 32x32 partial
//  products on one shared multiplier, one xor-shift between them, a final step.
//  an item takes one splitmix64 after accept, two when the seed must be mixed again
//  (after reset, after a restart item or after a write to a used register).
//  reset is synchronous; the seed is mixed lazily on the first item.
//  a finished item waits in the output register; a stalled output holds the
//  sequencer in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module gilbert_elliott_loss_chain (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     restart,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          drop,
  output logic                          chain_bad_next,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [gelc_pkg::WordW-1:0] cfg_data
);

  localparam int unsigned W = gelc_pkg::WordW;
  localparam int unsigned H = gelc_pkg::HalfW;

  gelc_pkg::state_t  state;
  gelc_pkg::pp_sel_t pp;
  logic              rnd;         // 0: first multiply round, 1: second
  logic              seed_phase;  // hashing the raw seed, not a draw
  logic              stale;       // mixed seed must be recomputed
  logic [W-1:0]      a;
  logic [W-1:0]      acc;
  logic [W-1:0]      mixed_seed;
  logic [W-1:0]      count;
  logic              chain_bad;
  logic [W-1:0]      raw_seed;
  logic [W-1:0]      enter_thr;
  logic [W-1:0]      leave_thr;

  logic [H-1:0]      mul_a;
  logic [H-1:0]      mul_b;
  logic [W-1:0]      mul_k;
  logic [W-1:0]      prod;
  logic [W-1:0]      add_sum;
  logic [W-1:0]      fin;
  logic              bad_upd;
  logic              out_free;
  logic              fin_fire;

  assign in_ready = (state == gelc_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign fin_fire = (state == gelc_pkg::S_FIN) && !seed_phase && out_free;

  // shared 32x32 multiplier, low 64 bits of a 64x64 product over three steps
  assign mul_k = rnd ? gelc_pkg::MixMul2 : gelc_pkg::MixMul1;
  assign mul_a = (pp == gelc_pkg::PP_HI_LO) ? a[W-1:H] : a[H-1:0];
  assign mul_b = (pp == gelc_pkg::PP_LO_HI) ? mul_k[W-1:H] : mul_k[H-1:0];
  assign prod  = {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};

  assign add_sum = acc + gelc_pkg::MixAdd;
  assign fin     = acc ^ (acc >> gelc_pkg::Shift3);

  assign bad_upd = chain_bad ? !(fin < leave_thr) : (fin < enter_thr);

  // a new item replaces the one leaving in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gelc_pkg::S_IDLE;
      pp         <= gelc_pkg::PP_LO_LO;
      rnd        <= 1'b0;
      seed_phase <= 1'b0;
      stale      <= 1'b1;
      count      <= '0;
      chain_bad  <= 1'b0;
      raw_seed   <= '0;
      enter_thr  <= '0;
      leave_thr  <= '0;
    end else begin
      if (cfg_we && cfg_index != gelc_pkg::REG_UNUSED) begin
        unique case (gelc_pkg::reg_index_t'(cfg_index))
          gelc_pkg::REG_RAW_SEED:  raw_seed  <= cfg_data;
          gelc_pkg::REG_ENTER_BAD: enter_thr <= cfg_data;
          gelc_pkg::REG_LEAVE_BAD: leave_thr <= cfg_data;
          default: ;
        endcase
        stale     <= 1'b1;
        count     <= '0;
        chain_bad <= 1'b0;
      end

      unique case (state)
        gelc_pkg::S_IDLE: begin
          if (in_valid) begin
            state <= gelc_pkg::S_ADD;
            if (restart || stale) begin
              seed_phase <= 1'b1;
              acc        <= raw_seed;
              count      <= '0;
              chain_bad  <= 1'b0;
            end else begin
              seed_phase <= 1'b0;
              acc        <= mixed_seed ^ count;
            end
          end
        end
        gelc_pkg::S_ADD: begin
          a     <= add_sum ^ (add_sum >> gelc_pkg::Shift1);
          rnd   <= 1'b0;
          pp    <= gelc_pkg::PP_LO_LO;
          state <= gelc_pkg::S_MUL;
        end
        gelc_pkg::S_MUL: begin
          unique case (pp)
            gelc_pkg::PP_LO_LO: begin
              acc <= prod;
              pp  <= gelc_pkg::PP_LO_HI;
            end
            gelc_pkg::PP_LO_HI: begin
              acc <= acc + {prod[H-1:0], {H{1'b0}}};
              pp  <= gelc_pkg::PP_HI_LO;
            end
            default: begin
              acc   <= acc + {prod[H-1:0], {H{1'b0}}};
              pp    <= gelc_pkg::PP_LO_LO;
              state <= rnd ? gelc_pkg::S_FIN : gelc_pkg::S_XOR;
            end
          endcase
        end
        gelc_pkg::S_XOR: begin
          a     <= acc ^ (acc >> gelc_pkg::Shift2);
          rnd   <= 1'b1;
          state <= gelc_pkg::S_MUL;
        end
        gelc_pkg::S_FIN: begin
          if (seed_phase) begin
            // seed ready, now hash the draw for this item
            mixed_seed <= fin;
            stale      <= 1'b0;
            seed_phase <= 1'b0;
            acc        <= fin ^ count;
            state      <= gelc_pkg::S_ADD;
          end else if (out_free) begin
            drop           <= chain_bad;
            chain_bad_next <= bad_upd;
            chain_bad      <= bad_upd;
            count          <= count + 1'b1;
            state          <= gelc_pkg::S_IDLE;
          end
        end
        default: state <= gelc_pkg::S_IDLE;
      endcase
    end
  end

endmodule : gilbert_elliott_loss_chain

`default_nettype wire

// ===== dv/gelc_loss_scoreboard.sv =====
// ----------------------------------------------------------------------------
// gelc_loss_scoreboard: loss chain predictor and result compare
// tracks register writes and accepted attempts, predicts drop and next state
// with its own splitmix64 chain, and compares them in order with the results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gelc_loss_scoreboard (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic                       restart,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic                       drop,
  input  wire logic                       chain_bad_next,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [gelc_pkg::WordW-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct packed {
    logic drop;
    logic bad_next;
  } loss_result_t;

  loss_result_t                loss_q[$];
  loss_result_t                want;
  logic [gelc_pkg::WordW-1:0]  seed_reg;
  logic [gelc_pkg::WordW-1:0]  enter_thr;
  logic [gelc_pkg::WordW-1:0]  leave_thr;
  logic [gelc_pkg::WordW-1:0]  mixed_seed;
  logic [gelc_pkg::WordW-1:0]  attempt_count;
  logic [gelc_pkg::WordW-1:0]  draw;
  logic                        chain_bad;
  logic                        was_bad;

  function automatic logic [gelc_pkg::WordW-1:0] splitmix64(
    input logic [gelc_pkg::WordW-1:0] x
  );
    logic [gelc_pkg::WordW-1:0] z;
    z = x + gelc_pkg::MixAdd;
    z = (z ^ (z >> gelc_pkg::Shift1)) * gelc_pkg::MixMul1;
    z = (z ^ (z >> gelc_pkg::Shift2)) * gelc_pkg::MixMul2;
    return z ^ (z >> gelc_pkg::Shift3);
  endfunction

  task automatic restart_chain();
    mixed_seed    = splitmix64(seed_reg);
    attempt_count = '0;
    chain_bad     = 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    mismatches = mismatches + 1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seed_reg  = '0;
      enter_thr = '0;
      leave_thr = '0;
      restart_chain();
      loss_q.delete();
    end else begin
      // any valid register write restarts the chain, the unused index does not
      if (cfg_we) begin
        case (gelc_pkg::reg_index_t'(cfg_index))
          gelc_pkg::REG_RAW_SEED: begin
            seed_reg = cfg_data;
            restart_chain();
          end
          gelc_pkg::REG_ENTER_BAD: begin
            enter_thr = cfg_data;
            restart_chain();
          end
          gelc_pkg::REG_LEAVE_BAD: begin
            leave_thr = cfg_data;
            restart_chain();
          end
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (loss_q.size() == 0) begin
          report_mismatch($sformatf("result with no item waiting (drop %0b next %0b)",
                                    drop, chain_bad_next));
        end else begin
          want = loss_q.pop_front();
          if (drop !== want.drop) begin
            report_mismatch($sformatf("drop got %0b expected %0b", drop, want.drop));
          end
          if (chain_bad_next !== want.bad_next) begin
            report_mismatch($sformatf("chain_bad_next got %0b expected %0b",
                                      chain_bad_next, want.bad_next));
          end
        end
      end

      if (in_valid && in_ready) begin
        if (restart) begin
          restart_chain();
        end
        was_bad       = chain_bad;
        draw          = splitmix64(mixed_seed ^ attempt_count);
        attempt_count = attempt_count + 1'b1;
        if (!was_bad) begin
          chain_bad = (draw < enter_thr);
        end else begin
          chain_bad = !(draw < leave_thr);
        end
        loss_q.push_back('{drop: was_bad, bad_next: chain_bad});
      end
    end
    outstanding <= loss_q.size();
  end

endmodule : gelc_loss_scoreboard

// ===== dv/gilbert_elliott_loss_chain_test.sv =====
// ----------------------------------------------------------------------------
// gilbert_elliott_loss_chain_test: top level bench for the loss chain
// directed attempts over threshold extremes and restarts, then random
// register settings and attempts under four idling phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gilbert_elliott_loss_chain_test;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       restart   = 1'b0;
  logic                       out_ready = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [1:0]                 cfg_index = gelc_pkg::REG_RAW_SEED;
  logic [gelc_pkg::WordW-1:0] cfg_data  = '0;
  logic                       in_ready;
  logic                       out_valid;
  logic                       drop;
  logic                       chain_bad_next;
  int                         mismatches;
  int                         outstanding;
  int                         idle_pct  = 0;
  int                         stall_pct = 0;

  gilbert_elliott_loss_chain dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drop           (drop),
    .chain_bad_next (chain_bad_next),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  gelc_loss_scoreboard loss_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .drop           (drop),
    .chain_bad_next (chain_bad_next),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [gelc_pkg::WordW-1:0] pick_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()} >> $urandom_range(3);
    endcase
  endfunction

  task automatic set_idling(input int phase);
    case (phase)
      0: begin
        idle_pct  = 0;
        stall_pct <= 0;
      end
      1: begin
        idle_pct  = 58;
        stall_pct <= 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct <= 58;
      end
      default: begin
        idle_pct  = 8;
        stall_pct <= 8;
      end
    endcase
  endtask

  // one attempt; valid stays up across back-to-back items
  task automatic send_attempt(input logic rs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input gelc_pkg::reg_index_t idx,
                           input logic [gelc_pkg::WordW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: thresholds zero, the chain never leaves good
    set_idling(0);
    repeat (3) send_attempt(1'b0);
    send_attempt(1'b1);
    drain();
    // unused index must neither store nor restart
    write_reg(gelc_pkg::REG_UNUSED, '1);
    repeat (2) send_attempt(1'b0);
    drain();
    // enter bad on nearly every draw, never leave
    write_reg(gelc_pkg::REG_ENTER_BAD, '1);
    repeat (3) send_attempt(1'b0);
    send_attempt(1'b1);
    drain();
    // leave on nearly every draw too, so the chain toggles
    write_reg(gelc_pkg::REG_LEAVE_BAD, '1);
    repeat (4) send_attempt(1'b0);
    drain();
    write_reg(gelc_pkg::REG_RAW_SEED, '1);
    repeat (2) send_attempt(1'b0);
    drain();
    write_reg(gelc_pkg::REG_ENTER_BAD, 64'h8000_0000_0000_0000);
    write_reg(gelc_pkg::REG_LEAVE_BAD, 64'h4000_0000_0000_0000);
    repeat (2) send_attempt(1'b0);
    send_attempt(1'b1);
    send_attempt(1'b0);

    for (int seg = 0; seg < 10; seg++) begin
      drain();
      set_idling(seg % 4);
      if ($urandom_range(3) != 0) begin
        write_reg(gelc_pkg::REG_RAW_SEED, {$urandom(), $urandom()});
      end
      if ($urandom_range(3) != 0) begin
        write_reg(gelc_pkg::REG_ENTER_BAD, pick_threshold());
      end
      if ($urandom_range(3) != 0) begin
        write_reg(gelc_pkg::REG_LEAVE_BAD, pick_threshold());
      end
      if ($urandom_range(4) == 0) begin
        write_reg(gelc_pkg::REG_UNUSED, {$urandom(), $urandom()});
      end
      repeat (75) send_attempt($urandom_range(99) < 5);
    end

    drain();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : gilbert_elliott_loss_chain_test

// ===== gilbert_elliott_loss_chain.f =====
hw/rtl/gelc_pkg.sv
hw/rtl/gilbert_elliott_loss_chain.sv
dv/gelc_loss_scoreboard.sv
dv/gilbert_elliott_loss_chain_test.sv
